[rtl/tgr_pkg.sv]
package tgr_pkg;

  localparam logic [63:0] IV_A = 64'h0123456789ABCDEF;
  localparam logic [63:0] IV_B = 64'hFEDCBA9876543210;
  localparam logic [63:0] IV_C = 64'hF096A5B4C3B2E187;

  localparam logic [63:0] KS_CONST_0 = 64'hA5A5A5A5A5A5A5A5;
  localparam logic [63:0] KS_CONST_1 = 64'h0123456789ABCDEF;

  // generator seed text, eight bytes to a word, first character in bits 7:0
  localparam logic [63:0] SEED_WORDS [8] = '{
    64'h202D207265676954, 64'h4E20747361462041,
    64'h2068736148207765, 64'h6E6F6974636E7546,
    64'h736F52207962202C, 64'h737265646E412073,
    64'h4520646E61206E6F, 64'h6D6168694220696C
  };

  localparam int SBOXES = 4;
  localparam int LANES  = 8;

  typedef struct packed {
    logic busy;
    logic done;
  } tgr_cmp_status_t;

  function automatic logic [7:0] byte_of(input logic [63:0] w, input logic [2:0] k);
    byte_of = w[{k, 3'b000} +: 8];
  endfunction

endpackage

[rtl/tgr_if.sv]
interface tgr_in_if;
  logic        valid;
  logic        ready;
  logic [63:0] message_word;
  logic [3:0]  valid_bytes;
  logic        last_word;
  modport source (output valid, message_word, valid_bytes, last_word, input ready);
  modport sink   (input valid, message_word, valid_bytes, last_word, output ready);
endinterface

interface tgr_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] hash_a;
  logic [63:0] hash_b;
  logic [63:0] hash_c;
  modport source (output valid, hash_a, hash_b, hash_c, input ready);
  modport sink   (input valid, hash_a, hash_b, hash_c, output ready);
endinterface

[rtl/tgr_sbox_ram.sv]
module tgr_sbox_ram (
  input  logic       clk,
  input  logic       re,
  input  logic [7:0] raddr0,
  input  logic [7:0] raddr1,
  output logic [7:0] rdata0,
  output logic [7:0] rdata1,
  input  logic       we,
  input  logic [7:0] waddr,
  input  logic [7:0] wdata
);

  logic [7:0] mem [256];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata0 <= mem[raddr0];
      rdata1 <= mem[raddr1];
    end
  end

endmodule

[rtl/tgr_compress.sv]
module tgr_compress (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [63:0]               blk    [8],
  input  logic [63:0]               cv_in  [3],
  output logic                      sbox_re,
  output logic [7:0]                addr0  [4],
  output logic [7:0]                addr1  [4],
  input  logic [63:0]               rd0    [4],
  input  logic [63:0]               rd1    [4],
  output logic [63:0]               cv_out [3],
  output tgr_pkg::tgr_cmp_status_t  status
);

  typedef enum logic [2:0] {C_IDLE, C_ISSUE, C_APPLY, C_KEYS, C_FINISH} cstate_t;

  cstate_t     state;
  logic [63:0] x [8];
  logic [63:0] x_next [8];
  logic [63:0] ra, rb, rc;
  logic [63:0] cvs [3];
  logic [1:0]  pass;
  logic [2:0]  rnd;
  logic [3:0]  kstep;
  logic        done;

  logic [63:0] cx, even_x, odd_x, a_new, bsum, b_new;

  always_comb begin
    cx = rc ^ x[rnd];
    for (int s = 0; s < tgr_pkg::SBOXES; s++) begin
      addr0[s] = tgr_pkg::byte_of(cx, 3'(2 * s));
      addr1[s] = tgr_pkg::byte_of(cx, 3'(7 - 2 * s));
    end
    even_x = rd0[0] ^ rd0[1] ^ rd0[2] ^ rd0[3];
    odd_x  = rd1[0] ^ rd1[1] ^ rd1[2] ^ rd1[3];
    a_new  = ra - even_x;
    bsum   = rb + odd_x;
    unique case (pass)
      2'd0:    b_new = bsum + (bsum << 2);
      2'd1:    b_new = (bsum << 3) - bsum;
      default: b_new = bsum + (bsum << 3);
    endcase
  end

  // key schedule, one dependent step a cycle
  always_comb begin
    x_next = x;
    unique case (kstep)
      4'd0:  x_next[0] = x[0] - (x[7] ^ tgr_pkg::KS_CONST_0);
      4'd1:  x_next[1] = x[1] ^ x[0];
      4'd2:  x_next[2] = x[2] + x[1];
      4'd3:  x_next[3] = x[3] - (x[2] ^ ((~x[1]) << 19));
      4'd4:  x_next[4] = x[4] ^ x[3];
      4'd5:  x_next[5] = x[5] + x[4];
      4'd6:  x_next[6] = x[6] - (x[5] ^ ((~x[4]) >> 23));
      4'd7:  x_next[7] = x[7] ^ x[6];
      4'd8:  x_next[0] = x[0] + x[7];
      4'd9:  x_next[1] = x[1] - (x[0] ^ ((~x[7]) << 19));
      4'd10: x_next[2] = x[2] ^ x[1];
      4'd11: x_next[3] = x[3] + x[2];
      4'd12: x_next[4] = x[4] - (x[3] ^ ((~x[2]) >> 23));
      4'd13: x_next[5] = x[5] ^ x[4];
      4'd14: x_next[6] = x[6] + x[5];
      default: x_next[7] = x[7] - (x[6] ^ tgr_pkg::KS_CONST_1);
    endcase
  end

  assign sbox_re     = (state == C_ISSUE);
  assign status.busy = (state != C_IDLE);
  assign status.done = done;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= C_IDLE;
      done  <= 1'b0;
      pass  <= '0;
      rnd   <= '0;
      kstep <= '0;
    end else begin
      done <= 1'b0;
      unique case (state)
        C_IDLE: begin
          if (start) begin
            x     <= blk;
            cvs   <= cv_in;
            ra    <= cv_in[0];
            rb    <= cv_in[1];
            rc    <= cv_in[2];
            pass  <= '0;
            rnd   <= '0;
            state <= C_ISSUE;
          end
        end
        C_ISSUE: begin
          rc    <= cx;
          state <= C_APPLY;
        end
        C_APPLY: begin
          // roles turn a,b,c -> b,c,a; after eight rounds this is the pass swap
          ra  <= b_new;
          rb  <= rc;
          rc  <= a_new;
          rnd <= rnd + 3'd1;
          if (rnd == 3'd7) begin
            if (pass == 2'd2) begin
              state <= C_FINISH;
            end else begin
              pass  <= pass + 2'd1;
              kstep <= '0;
              state <= C_KEYS;
            end
          end else begin
            state <= C_ISSUE;
          end
        end
        C_KEYS: begin
          x     <= x_next;
          kstep <= kstep + 4'd1;
          if (kstep == 4'd15) begin
            state <= C_ISSUE;
          end
        end
        C_FINISH: begin
          cv_out[0] <= ra ^ cvs[0];
          cv_out[1] <= rb - cvs[1];
          cv_out[2] <= rc + cvs[2];
          done      <= 1'b1;
          state     <= C_IDLE;
        end
        default: state <= C_IDLE;
      endcase
    end
  end

endmodule

[rtl/tiger_hash_192_top.sv]
// channel  | dir | payload                                  | accepted when
// msg      | in  | message_word, valid_bytes, last_word     | msg.valid && msg.ready
// digest   | out | hash_a, hash_b, hash_c                   | digest.valid && digest.ready
//
// after reset the s-box memories are filled and then shuffled by the table generator,
// which runs the compression unit itself; msg.ready first rises when the shuffle is done
// a word that does not close a block is pushed into the block buffer; a word that closes one
// also starts a compression (rounds on the shared round unit
// and its s-box read ports, plus 16 key schedule steps before each of the last two passes),
// and no new word is taken until that compression is done
// the last word adds padding pushes and one or two compressions before the digest
// digest is held in an output register; a new message is taken while it waits

module tiger_hash_192_top (
  input  logic       clk,
  input  logic       rst,
  tgr_in_if.sink     msg,
  tgr_out_if.source  digest
);

  typedef enum logic [3:0] {
    ST_FILL, ST_GEN_SEL, ST_GEN_WAIT, ST_SWAP_RD, ST_SWAP_W1, ST_SWAP_W2,
    ST_IDLE, ST_PUSH, ST_CSTART, ST_CWAIT, ST_DELIVER
  } state_t;

  typedef enum logic [1:0] {STEP_WORD, STEP_ONE, STEP_FILL} step_t;

  state_t      state;
  step_t       step;
  logic [7:0]  fill_cnt;
  logic [1:0]  sel;
  logic [2:0]  gpass;
  logic [7:0]  gi;
  logic [1:0]  gsb;
  logic [63:0] st [3];
  logic [63:0] chaining [3];
  logic [63:0] buffer [8];
  logic [2:0]  pos;
  logic [63:0] length;
  logic [63:0] pend;
  logic        is_last, is_full, flag_final, flag_plain;

  logic        cmp_start;
  logic [63:0] cmp_blk [8];
  logic [63:0] cmp_cv [3];
  logic        cmp_re;
  logic [7:0]  cmp_addr0 [4];
  logic [7:0]  cmp_addr1 [4];
  logic [63:0] rd0_w [4];
  logic [63:0] rd1_w [4];
  logic [63:0] cmp_cv_out [3];
  tgr_pkg::tgr_cmp_status_t cmp_status;

  logic       ram_re    [4][8];
  logic [7:0] ram_ra0   [4][8];
  logic [7:0] ram_ra1   [4][8];
  logic [7:0] ram_rd0   [4][8];
  logic [7:0] ram_rd1   [4][8];
  logic       ram_we    [4][8];
  logic [7:0] ram_wa    [4][8];
  logic [7:0] ram_wd    [4][8];

  logic        in_accept;
  logic [3:0]  v_sat;
  logic [63:0] first_word;
  logic [63:0] push_word;
  logic        gen_mode;

  assign in_accept = msg.valid && msg.ready;
  assign msg.ready = (state == ST_IDLE);
  assign gen_mode  = (state == ST_GEN_SEL) || (state == ST_GEN_WAIT);
  assign cmp_start = (state == ST_CSTART) || ((state == ST_GEN_SEL) && (sel == 2'd2));
  assign cmp_blk   = gen_mode ? tgr_pkg::SEED_WORDS : buffer;
  assign cmp_cv    = gen_mode ? st : chaining;

  always_comb begin
    v_sat = (msg.valid_bytes > 4'd8) ? 4'd8 : msg.valid_bytes;
    for (int k = 0; k < 8; k++) begin
      if (!msg.last_word || (4'(k) < v_sat)) begin
        first_word[8*k +: 8] = msg.message_word[8*k +: 8];
      end else if (4'(k) == v_sat) begin
        first_word[8*k +: 8] = 8'h01;
      end else begin
        first_word[8*k +: 8] = 8'h00;
      end
    end
  end

  always_comb begin
    unique case (step)
      STEP_WORD: push_word = pend;
      STEP_ONE:  push_word = 64'h1;
      default:   push_word = (pos == 3'd7) ? {length[60:0], 3'b000} : 64'h0;
    endcase
  end

  // s-box port steering: fill, generator swap or hash rounds
  always_comb begin
    for (int s = 0; s < tgr_pkg::SBOXES; s++) begin
      for (int l = 0; l < tgr_pkg::LANES; l++) begin
        ram_re[s][l]  = cmp_re;
        ram_ra0[s][l] = cmp_addr0[s];
        ram_ra1[s][l] = cmp_addr1[s];
        ram_we[s][l]  = 1'b0;
        ram_wa[s][l]  = gi;
        ram_wd[s][l]  = ram_rd1[s][l];
        unique case (state)
          ST_FILL: begin
            ram_we[s][l] = 1'b1;
            ram_wa[s][l] = fill_cnt;
            ram_wd[s][l] = fill_cnt;
          end
          ST_SWAP_RD: begin
            ram_re[s][l]  = (gsb == 2'(s));
            ram_ra0[s][l] = gi;
            ram_ra1[s][l] = tgr_pkg::byte_of(st[sel], 3'(l));
          end
          ST_SWAP_W1: begin
            ram_we[s][l] = (gsb == 2'(s));
          end
          ST_SWAP_W2: begin
            ram_we[s][l] = (gsb == 2'(s));
            ram_wa[s][l] = tgr_pkg::byte_of(st[sel], 3'(l));
            ram_wd[s][l] = ram_rd0[s][l];
          end
          default: ;
        endcase
        rd0_w[s][8*l +: 8] = ram_rd0[s][l];
        rd1_w[s][8*l +: 8] = ram_rd1[s][l];
      end
    end
  end

  for (genvar s = 0; s < tgr_pkg::SBOXES; s++) begin : g_sbox
    for (genvar l = 0; l < tgr_pkg::LANES; l++) begin : g_lane
      tgr_sbox_ram u_ram (
        .clk    (clk),
        .re     (ram_re[s][l]),
        .raddr0 (ram_ra0[s][l]),
        .raddr1 (ram_ra1[s][l]),
        .rdata0 (ram_rd0[s][l]),
        .rdata1 (ram_rd1[s][l]),
        .we     (ram_we[s][l]),
        .waddr  (ram_wa[s][l]),
        .wdata  (ram_wd[s][l])
      );
    end
  end

  tgr_compress u_compress (
    .clk     (clk),
    .rst     (rst),
    .start   (cmp_start),
    .blk     (cmp_blk),
    .cv_in   (cmp_cv),
    .sbox_re (cmp_re),
    .addr0   (cmp_addr0),
    .addr1   (cmp_addr1),
    .rd0     (rd0_w),
    .rd1     (rd1_w),
    .cv_out  (cmp_cv_out),
    .status  (cmp_status)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_FILL;
      step         <= STEP_WORD;
      fill_cnt     <= '0;
      sel          <= 2'd2;
      gpass        <= '0;
      gi           <= '0;
      gsb          <= '0;
      st           <= '{tgr_pkg::IV_A, tgr_pkg::IV_B, tgr_pkg::IV_C};
      chaining     <= '{tgr_pkg::IV_A, tgr_pkg::IV_B, tgr_pkg::IV_C};
      pos          <= '0;
      length       <= '0;
      flag_final   <= 1'b0;
      flag_plain   <= 1'b0;
      digest.valid <= 1'b0;
    end else begin
      // a delivery in this cycle sets valid itself
      if (digest.valid && digest.ready && (state != ST_DELIVER)) begin
        digest.valid <= 1'b0;
      end
      unique case (state)
        ST_FILL: begin
          fill_cnt <= fill_cnt + 8'd1;
          if (fill_cnt == 8'hFF) begin
            state <= ST_GEN_SEL;
          end
        end
        ST_GEN_SEL: begin
          if (sel == 2'd2) begin
            sel   <= 2'd0;
            state <= ST_GEN_WAIT;
          end else begin
            sel   <= sel + 2'd1;
            state <= ST_SWAP_RD;
          end
        end
        ST_GEN_WAIT: begin
          if (cmp_status.done) begin
            st    <= cmp_cv_out;
            state <= ST_SWAP_RD;
          end
        end
        ST_SWAP_RD: state <= ST_SWAP_W1;
        ST_SWAP_W1: state <= ST_SWAP_W2;
        ST_SWAP_W2: begin
          gsb   <= gsb + 2'd1;
          state <= ST_GEN_SEL;
          if (gsb == 2'd3) begin
            gi <= gi + 8'd1;
            if (gi == 8'hFF) begin
              gpass <= gpass + 3'd1;
              if (gpass == 3'd4) begin
                state <= ST_IDLE;
              end
            end
          end
        end
        ST_IDLE: begin
          if (in_accept) begin
            pend    <= first_word;
            is_last <= msg.last_word;
            is_full <= (v_sat == 4'd8);
            length  <= length + (msg.last_word ? {60'b0, v_sat} : 64'd8);
            step    <= STEP_WORD;
            state   <= ST_PUSH;
          end
        end
        ST_PUSH: begin
          buffer[pos] <= push_word;
          pos         <= pos + 3'd1;
          unique case (step)
            STEP_WORD: step <= is_full ? STEP_ONE : STEP_FILL;
            default:   step <= STEP_FILL;
          endcase
          if (pos == 3'd7) begin
            flag_final <= (step == STEP_FILL);
            flag_plain <= (step == STEP_WORD) && !is_last;
            state      <= ST_CSTART;
          end else if ((step == STEP_WORD) && !is_last) begin
            state <= ST_IDLE;
          end
        end
        ST_CSTART: state <= ST_CWAIT;
        ST_CWAIT: begin
          if (cmp_status.done) begin
            chaining <= cmp_cv_out;
            priority if (flag_final) state <= ST_DELIVER;
            else if (flag_plain)     state <= ST_IDLE;
            else                     state <= ST_PUSH;
          end
        end
        ST_DELIVER: begin
          if (!digest.valid || digest.ready) begin
            digest.hash_a <= chaining[0];
            digest.hash_b <= chaining[1];
            digest.hash_c <= chaining[2];
            digest.valid  <= 1'b1;
            chaining      <= '{tgr_pkg::IV_A, tgr_pkg::IV_B, tgr_pkg::IV_C};
            length        <= '0;
            state         <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_accept |=> !msg.ready)
    else $error("input taken again straight after a transaction");

  a_result_from_deliver: assert property (@(posedge clk) disable iff (rst)
    $rose(digest.valid) |-> $past(state == ST_DELIVER))
    else $error("digest raised outside delivery");

  a_start_when_free: assert property (@(posedge clk) disable iff (rst)
    cmp_start |-> !cmp_status.busy)
    else $error("compression started while busy");

  a_no_cmp_in_idle: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |-> !cmp_status.busy)
    else $error("compression still running while ready");

endmodule

[verif/tiger_hash_192_checker.sv]
`timescale 1ns / 1ps

module tiger_hash_192_checker (
  input  logic clk,
  input  logic rst,
  tgr_in_if    msg,
  tgr_out_if   digest,
  output int   mismatches,
  output int   hashes_waiting
);

  typedef logic [63:0] block_words_t [8];
  typedef logic [63:0] chain_words_t [3];

  typedef struct {
    logic [63:0] a;
    logic [63:0] b;
    logic [63:0] c;
  } digest_t;

  logic [63:0]  sbox [1024];
  chain_words_t chain;
  block_words_t blk;
  logic [2:0]   slot;
  logic [63:0]  byte_count;
  digest_t      digest_q [$];
  int           fail_count;

  function automatic void tiger_round(inout logic [63:0] a, inout logic [63:0] b,
                                      inout logic [63:0] c, input logic [63:0] x,
                                      input logic [63:0] mul);
    c = c ^ x;
    a = a - (sbox[c[7:0]] ^ sbox[256 + c[23:16]] ^ sbox[512 + c[39:32]] ^
             sbox[768 + c[55:48]]);
    b = b + (sbox[768 + c[15:8]] ^ sbox[512 + c[31:24]] ^ sbox[256 + c[47:40]] ^
             sbox[c[63:56]]);
    b = b * mul;
  endfunction

  function automatic chain_words_t compress(input block_words_t blk_in,
                                            input chain_words_t st);
    block_words_t x;
    logic [63:0]  a, b, c, t, mul;
    chain_words_t res;
    x = blk_in;
    a = st[0];
    b = st[1];
    c = st[2];
    for (int p = 0; p < 3; p++) begin
      if (p != 0) begin
        x[0] -= x[7] ^ tgr_pkg::KS_CONST_0; x[1] ^= x[0]; x[2] += x[1];
        x[3] -= x[2] ^ ((~x[1]) << 19);
        x[4] ^= x[3]; x[5] += x[4]; x[6] -= x[5] ^ ((~x[4]) >> 23); x[7] ^= x[6];
        x[0] += x[7]; x[1] -= x[0] ^ ((~x[7]) << 19); x[2] ^= x[1]; x[3] += x[2];
        x[4] -= x[3] ^ ((~x[2]) >> 23); x[5] ^= x[4]; x[6] += x[5];
        x[7] -= x[6] ^ tgr_pkg::KS_CONST_1;
      end
      mul = (p == 0) ? 64'd5 : (p == 1) ? 64'd7 : 64'd9;
      tiger_round(a, b, c, x[0], mul);
      tiger_round(b, c, a, x[1], mul);
      tiger_round(c, a, b, x[2], mul);
      tiger_round(a, b, c, x[3], mul);
      tiger_round(b, c, a, x[4], mul);
      tiger_round(c, a, b, x[5], mul);
      tiger_round(a, b, c, x[6], mul);
      tiger_round(b, c, a, x[7], mul);
      t = a; a = c; c = b; b = t;
    end
    res[0] = a ^ st[0];
    res[1] = b - st[1];
    res[2] = c + st[2];
    return res;
  endfunction

  // table generator: byte-wise shuffle driven by the compression of the seed text
  function automatic void build_sboxes();
    chain_words_t st;
    block_words_t seed;
    int           sel, other;
    logic [7:0]   v1, v2;
    sel = 2;
    for (int k = 0; k < 8; k++) seed[k] = tgr_pkg::SEED_WORDS[k];
    st[0] = tgr_pkg::IV_A;
    st[1] = tgr_pkg::IV_B;
    st[2] = tgr_pkg::IV_C;
    for (int i = 0; i < 1024; i++) sbox[i] = {8{i[7:0]}};
    for (int pass = 0; pass < 5; pass++)
      for (int i = 0; i < 256; i++)
        for (int sb = 0; sb < 1024; sb += 256) begin
          sel++;
          if (sel >= 3) begin
            sel = 0;
            st = compress(seed, st);
          end
          for (int col = 0; col < 8; col++) begin
            other = sb + st[sel][col*8 +: 8];
            v1 = sbox[sb + i][col*8 +: 8];
            v2 = sbox[other][col*8 +: 8];
            sbox[sb + i][col*8 +: 8] = v2;
            sbox[other][col*8 +: 8] = v1;
          end
        end
  endfunction

  function automatic void restart_message();
    chain[0] = tgr_pkg::IV_A;
    chain[1] = tgr_pkg::IV_B;
    chain[2] = tgr_pkg::IV_C;
    slot = 3'd0;
    byte_count = 64'd0;
  endfunction

  function automatic void load_word(input logic [63:0] w);
    blk[slot] = w;
    slot = slot + 3'd1;
    if (slot == 3'd0) chain = compress(blk, chain);
  endfunction

  function automatic void absorb(input logic [63:0] w, input logic [3:0] nbytes,
                                 input logic fin);
    int      n;
    digest_t d;
    if (!fin) begin
      byte_count += 64'd8;
      load_word(w);
      return;
    end
    n = (nbytes > 4'd8) ? 8 : int'(nbytes);
    byte_count += 64'(n);
    if (n == 8) begin
      load_word(w);
      load_word(64'h01);
    end else begin
      load_word((w & ((64'd1 << (8 * n)) - 64'd1)) | (64'h01 << (8 * n)));
    end
    while (slot != 3'd7) load_word(64'd0);
    load_word(byte_count << 3);
    d.a = chain[0];
    d.b = chain[1];
    d.c = chain[2];
    digest_q.push_back(d);
    restart_message();
  endfunction

  initial begin
    build_sboxes();
    for (int k = 0; k < 8; k++) blk[k] = 64'd0;
    restart_message();
    fail_count = 0;
  end

  always @(posedge clk) begin
    digest_t d;
    if (!rst) begin
      if (msg.valid && msg.ready)
        absorb(msg.message_word, msg.valid_bytes, msg.last_word);
      if (digest.valid && digest.ready) begin
        if (digest_q.size() == 0) begin
          $display("%0t: digest transaction with nothing expected: %h %h %h", $time,
                   digest.hash_a, digest.hash_b, digest.hash_c);
          fail_count++;
        end else begin
          d = digest_q.pop_front();
          if (digest.hash_a !== d.a) begin
            $display("%0t: hash_a expected %h actual %h", $time, d.a, digest.hash_a);
            fail_count++;
          end
          if (digest.hash_b !== d.b) begin
            $display("%0t: hash_b expected %h actual %h", $time, d.b, digest.hash_b);
            fail_count++;
          end
          if (digest.hash_c !== d.c) begin
            $display("%0t: hash_c expected %h actual %h", $time, d.c, digest.hash_c);
            fail_count++;
          end
        end
      end
    end
    mismatches <= fail_count;
    hashes_waiting <= digest_q.size();
  end

endmodule

[verif/tiger_hash_192_top_tb.sv]
`timescale 1ns / 1ps

module tiger_hash_192_top_tb;

  logic clk;
  logic rst;
  int   mismatches;
  int   hashes_waiting;
  int   sender_idle_pct;
  int   recv_idle_pct;
  int   hold_req;
  int   hold_seen;
  int   hold_left;
  int   words_sent;

  tgr_in_if  msg_ch ();
  tgr_out_if dig_ch ();

  tiger_hash_192_top dut (
    .clk    (clk),
    .rst    (rst),
    .msg    (msg_ch),
    .digest (dig_ch)
  );

  tiger_hash_192_checker checker_i (
    .clk            (clk),
    .rst            (rst),
    .msg            (msg_ch),
    .digest         (dig_ch),
    .mismatches     (mismatches),
    .hashes_waiting (hashes_waiting)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #50_000_000;
    $display("tiger_hash_192_top verification failed");
    $finish;
  end

  // receiver: random back-pressure, plus long hold-offs on request
  initial begin
    dig_ch.ready = 1'b0;
    hold_seen = 0;
    hold_left = 0;
  end

  always @(posedge clk) begin
    if (rst) begin
      dig_ch.ready <= 1'b0;
    end else begin
      if (hold_req != hold_seen) begin
        hold_seen = hold_req;
        hold_left = 3000;
      end
      if (hold_left > 0) begin
        hold_left--;
        dig_ch.ready <= 1'b0;
      end else begin
        dig_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  task automatic send_word(input logic [63:0] w, input logic [3:0] nbytes,
                           input logic fin);
    while ($urandom_range(99) < sender_idle_pct) begin
      msg_ch.valid <= 1'b0;
      @(posedge clk);
    end
    msg_ch.valid <= 1'b1;
    msg_ch.message_word <= w;
    msg_ch.valid_bytes <= nbytes;
    msg_ch.last_word <= fin;
    @(posedge clk);
    while (!msg_ch.ready) @(posedge clk);
    words_sent++;
  endtask

  task automatic send_message(input int body_words, input logic [3:0] tail_bytes);
    for (int k = 0; k < body_words; k++)
      send_word({$urandom, $urandom}, 4'($urandom_range(15)), 1'b0);
    send_word({$urandom, $urandom}, tail_bytes, 1'b1);
  endtask

  task automatic drain_digests();
    msg_ch.valid <= 1'b0;
    @(posedge clk);
    @(posedge clk);
    while (hashes_waiting != 0) @(posedge clk);
  endtask

  initial begin
    int phase;
    int len;
    rst = 1'b1;
    hold_req = 0;
    words_sent = 0;
    sender_idle_pct = 26;
    recv_idle_pct = 79;
    phase = 0;
    msg_ch.valid <= 1'b0;
    msg_ch.message_word <= 64'd0;
    msg_ch.valid_bytes <= 4'd0;
    msg_ch.last_word <= 1'b0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // empty message, all-ones word thrown away by padding
    send_word('1, 4'd0, 1'b1);
    // full last word of zeros: padding byte goes into a fresh word
    send_word(64'd0, 4'd8, 1'b1);
    // padding lands in word seven, so an extra block follows
    for (int k = 0; k < 7; k++) send_word('1, 4'd15, 1'b0);
    send_word('1, 4'd3, 1'b1);
    // full last word in slot six
    for (int k = 0; k < 6; k++) send_word(64'd0, 4'd0, 1'b0);
    send_word('1, 4'd8, 1'b1);
    // valid counts above eight saturate
    send_word({$urandom, $urandom}, 4'd15, 1'b1);
    send_word({$urandom, $urandom}, 4'd9, 1'b1);

    while (words_sent < 850) begin
      if (phase == 0 && words_sent >= 300) begin
        phase = 1;
        sender_idle_pct = 79;
        recv_idle_pct = 26;
        hold_req++;
      end else if (phase == 1 && words_sent >= 600) begin
        phase = 2;
        drain_digests();
        sender_idle_pct = 0;
        recv_idle_pct = 0;
      end
      len = ($urandom_range(99) < 85) ? $urandom_range(0, 9) : $urandom_range(10, 24);
      send_message(len, 4'($urandom_range(15)));
    end

    drain_digests();
    repeat (300) @(posedge clk);
    if (mismatches == 0 && hashes_waiting == 0)
      $display("tiger_hash_192_top verification clean");
    else
      $display("tiger_hash_192_top verification failed");
    $finish;
  end

endmodule

[sim.f]
rtl/tgr_pkg.sv
rtl/tgr_if.sv
rtl/tgr_sbox_ram.sv
rtl/tgr_compress.sv
rtl/tiger_hash_192_top.sv
verif/tiger_hash_192_checker.sv
verif/tiger_hash_192_top_tb.sv
